[rtl/dhkt_pkg.sv]
// Shared types, codes and constants for the decaying hot key table.
package dhkt_pkg;

  localparam int unsigned DefaultEntries = 64;
  localparam int unsigned FracBits       = 16;
  localparam logic [31:0] OneFix         = 32'h0001_0000;
  localparam logic [31:0] DefaultWindow  = 32'h0001_0000;

  typedef enum logic [1:0] {
    OP_DECAY = 2'd0,
    OP_HEAT  = 2'd1,
    OP_GET   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    RES_DECAYED   = 3'd0,
    RES_HEAT_HIT  = 3'd1,
    RES_HEAT_INS  = 3'd2,
    RES_HEAT_DROP = 3'd3,
    RES_GET_HIT   = 3'd4,
    RES_GET_MISS  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_DIV,
    S_SCAN,
    S_FINISH
  } state_e;

endpackage

[rtl/dhkt_div.sv]
// Restoring divider giving the 16-bit fraction of num / den, one bit per cycle.
module dhkt_div import dhkt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         num_i,
  input  logic [31:0]         den_i,
  output logic                done_o,
  output logic [FracBits-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(FracBits);

  logic                busy_q;
  logic                done_q;
  logic [CntW-1:0]     cnt_q;
  logic [31:0]         rem_q;
  logic [31:0]         den_q;
  logic [FracBits-1:0] quo_q;

  logic [32:0] shifted;
  logic        ge;
  logic [31:0] rem_nxt;

  // Trial subtract of the shifted remainder; remainder stays below den
  assign shifted = {rem_q, 1'b0};
  assign ge      = shifted >= {1'b0, den_q};
  assign rem_nxt = ge ? 32'(shifted - {1'b0, den_q}) : shifted[31:0];

  // Sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(FracBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift in one quotient bit per step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_nxt;
      quo_q <= {quo_q[FracBits-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[rtl/decaying_hot_key_table.sv]
// Top level: key/temperature table with linear decay, held in one synchronous memory.
// Heat and get items walk the table and then finish; decay items first prepare the ratio and
// run the 16-step fraction divider, skipped when the span is at or past the window or time
// goes back. A new item is taken only in idle, after the last one's result is registered;
// finishing waits while an earlier result is still held. Every item walks the one read
// port, one entry per cycle. Reset first runs a clearing pass, one zero write per entry.
module decaying_hot_key_table import dhkt_pkg::*; #(
  parameter int unsigned TableEntries = DefaultEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] key_hash_i,
  input  logic [47:0] now_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] temperature_o
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [CntW-1:0] LastIdx = CntW'(TableEntries - 1);
  localparam logic [CntW-1:0] EndCnt  = CntW'(TableEntries);

  state_e state_q, state_d;

  logic [31:0]         window_q;
  logic [47:0]         last_time_q;
  logic [1:0]          op_q;
  logic [31:0]         key_q;
  logic [47:0]         now_q;
  logic [16:0]         k_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                rvld_q;
  logic [IdxW-1:0]     ridx_q;
  logic [63:0]         rdata_q;
  logic                hit_q;
  logic [IdxW-1:0]     hit_idx_q;
  logic [31:0]         hit_heat_q;
  logic [31:0]         cold_q;
  logic [IdxW-1:0]     pick_q;
  logic                out_valid_q;
  logic [2:0]          status_q;
  logic [31:0]         temp_q;

  logic [63:0]         mem_q [TableEntries];

  // Control produced by the output block
  logic                in_fire;
  logic                issue;
  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  logic [63:0]         mem_wdata;
  logic                div_start;
  logic                fin_fire;
  status_e             res_status;
  logic [31:0]         res_temp;

  // Decay ratio preparation
  logic [48:0]         d_full;
  logic [31:0]         w_eff;
  logic                time_back;
  logic                span_full;
  logic                div_need;
  logic                div_done;
  logic [FracBits-1:0] div_quo;

  // Read data views
  logic [31:0]         rkey;
  logic [31:0]         rheat;
  logic [48:0]         prod;
  logic [32:0]         heat_sum;
  logic [31:0]         heat_sat;

  assign d_full    = {1'b0, now_q} - {1'b0, last_time_q};
  assign w_eff     = (window_q == '0) ? 32'd1 : window_q;
  assign time_back = d_full[48];
  assign span_full = d_full[47:0] >= {16'b0, w_eff};
  assign div_need  = !time_back && !span_full;

  assign rkey     = rdata_q[63:32];
  assign rheat    = rdata_q[31:0];
  assign prod     = {17'b0, rheat} * {32'b0, k_q};
  assign heat_sum = {1'b0, hit_heat_q} + {1'b0, OneFix};
  assign heat_sat = heat_sum[32] ? '1 : heat_sum[31:0];

  dhkt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (d_full[31:0]),
    .den_i   (w_eff),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (cnt_q == LastIdx) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) state_d = (op_i == OP_DECAY) ? S_PREP : S_SCAN;
      end
      S_PREP:   state_d = div_need ? S_DIV : S_SCAN;
      S_DIV:    if (div_done) state_d = S_SCAN;
      S_SCAN:   if (cnt_q == EndCnt && rvld_q) state_d = S_FINISH;
      S_FINISH: if (fin_fire) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, memory port and result selection
  always_comb begin
    in_fire    = 1'b0;
    issue      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = ridx_q;
    mem_wdata  = {rkey, prod[47:16]};
    div_start  = 1'b0;
    fin_fire   = 1'b0;
    res_status = RES_DECAYED;
    res_temp   = '0;
    cnt_d      = '0;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[IdxW-1:0];
        mem_wdata = '0;
        cnt_d     = cnt_q + 1'b1;
      end
      S_IDLE: begin
        in_fire = in_valid_i;
      end
      S_PREP: begin
        div_start = div_need;
      end
      S_SCAN: begin
        issue = cnt_q != EndCnt;
        cnt_d = issue ? cnt_q + 1'b1 : cnt_q;
        // scale each entry on its way back during a decay walk
        mem_we = rvld_q && (op_q == OP_DECAY);
      end
      S_FINISH: begin
        fin_fire = !out_valid_q || out_ready_i;
        if (op_q == OP_DECAY) begin
          res_status = RES_DECAYED;
        end else if (op_q == OP_HEAT) begin
          if (hit_q) begin
            res_status = RES_HEAT_HIT;
            res_temp   = heat_sat;
            mem_we     = fin_fire;
            mem_waddr  = hit_idx_q;
            mem_wdata  = {key_q, heat_sat};
          end else if (cold_q < OneFix) begin
            res_status = RES_HEAT_INS;
            res_temp   = OneFix;
            mem_we     = fin_fire;
            mem_waddr  = pick_q;
            mem_wdata  = {key_q, OneFix};
          end else begin
            res_status = RES_HEAT_DROP;
          end
        end else begin
          res_status = hit_q ? RES_GET_HIT : RES_GET_MISS;
          res_temp   = hit_q ? hit_heat_q : '0;
        end
      end
      default: ;
    endcase
  end

  // Table memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (issue) rdata_q <= mem_q[cnt_q[IdxW-1:0]];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
      window_q    <= DefaultWindow;
      last_time_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rvld_q  <= issue;
      if (cfg_we_i) window_q <= cfg_wdata_i;
      if (fin_fire && op_q == OP_DECAY) last_time_q <= now_q;
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item, decay factor, scan tracking and result registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= op_i;
      key_q  <= key_hash_i;
      now_q  <= now_time_i;
      hit_q  <= 1'b0;
      cold_q <= '0;
      pick_q <= '0;
    end
    if (issue) ridx_q <= cnt_q[IdxW-1:0];
    // pick the decay factor: full hold, full decay, or from the divider
    if (state_q == S_PREP) begin
      k_q <= time_back ? {1'b0, OneFix[15:0]} | 17'h10000 : 17'h0;
    end
    if (state_q == S_DIV && div_done) begin
      k_q <= 17'h10000 - {1'b0, div_quo};
    end
    // track first key match and the earliest coldest entry
    if (rvld_q && state_q == S_SCAN && !hit_q) begin
      if (rkey == key_q) begin
        hit_q      <= 1'b1;
        hit_idx_q  <= ridx_q;
        hit_heat_q <= rheat;
      end else if (ridx_q == '0 || rheat < cold_q) begin
        cold_q <= rheat;
        pick_q <= ridx_q;
      end
    end
    if (fin_fire) begin
      status_q <= res_status;
      temp_q   <= res_temp;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign temperature_o = temp_q;

endmodule
